FILE: src/sts_pkg.sv
// Shared constants and types for the slot table with sort.
package sts_pkg;

    localparam int SLOTS        = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int ENT_W        = KEY_BITS + PAYLOAD_BITS;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_SORT   = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic found;
        t_idx idx;
    } t_free;

endpackage

FILE: src/sts_free_find.sv
// Priority encoder that picks the lowest free slot from the valid bits.
module sts_free_find (
    input  logic [sts_pkg::SLOTS-1:0] i_valid_bits,
    output sts_pkg::t_free            o_free
);

    always_comb begin
        o_free.found = 1'b0;
        o_free.idx   = '0;
        for (int k = sts_pkg::SLOTS - 1; k >= 0; k--) begin
            if (!i_valid_bits[k]) begin
                o_free.found = 1'b1;
                o_free.idx   = sts_pkg::IDX_W'(k);
            end
        end
    end

endmodule

FILE: src/slot_table_with_sort.sv
// Slot table with insert, remove, search and stable in-place insertion sort.
//
//  channel | valid    | ready    | fields
//  --------+----------+----------+-----------------------------------------------
//  input   | i_valid  | o_ready  | i_opcode, i_key_id, i_entry_payload
//  output  | o_valid  | i_ready  | o_success, o_found_key, o_found_payload,
//          |          |          | o_occupied_count, o_table_empty, o_table_full
//
// Insert writes the lowest free slot as the item is taken; remove and search step through the
// slots, one slot per cycle through the entry memory's single read port, and stop at the first hit.
// Sort takes slots 1..SLOTS-1 in turn and moves each one down past occupied slots with larger keys
// (past every occupied slot if it is empty), one compare and one shift per cycle through the same memory port.
// Reset clears the valid bits and count; the entry memory itself is not cleared.
// One item is in work at a time; the next one is taken while the last word waits at the output.
module slot_table_with_sort (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [sts_pkg::KEY_BITS-1:0]      i_key_id,
    input  logic [sts_pkg::PAYLOAD_BITS-1:0]  i_entry_payload,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_success,
    output logic [sts_pkg::KEY_BITS-1:0]      o_found_key,
    output logic [sts_pkg::PAYLOAD_BITS-1:0]  o_found_payload,
    output logic [sts_pkg::CNT_W-1:0]         o_occupied_count,
    output logic                              o_table_empty,
    output logic                              o_table_full
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SLOAD = 3'd2;
    localparam logic [2:0] S_SCMP  = 3'd3;
    localparam logic [2:0] S_SPUT  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam sts_pkg::t_idx IDX_ONE  = sts_pkg::IDX_W'(1);
    localparam sts_pkg::t_idx IDX_TWO  = sts_pkg::IDX_W'(2);
    localparam sts_pkg::t_idx IDX_LAST = sts_pkg::IDX_W'(sts_pkg::SLOTS - 1);
    localparam logic [sts_pkg::CNT_W-1:0] CNT_ONE  = sts_pkg::CNT_W'(1);
    localparam logic [sts_pkg::CNT_W-1:0] CNT_FULL = sts_pkg::CNT_W'(sts_pkg::SLOTS);

    logic [2:0]                         r_state, n_state;
    logic [sts_pkg::SLOTS-1:0]          r_valid, n_valid;
    logic [sts_pkg::CNT_W-1:0]          r_count, n_count;
    sts_pkg::t_idx                      r_idx, n_idx;
    sts_pkg::t_idx                      r_i, n_i;
    sts_pkg::t_idx                      r_j, n_j;
    logic                               r_rm, n_rm;
    logic                               r_hv, n_hv;
    logic [sts_pkg::KEY_BITS-1:0]       r_hk, n_hk;
    logic [sts_pkg::PAYLOAD_BITS-1:0]   r_hd, n_hd;
    logic                               r_ok, n_ok;
    logic [sts_pkg::KEY_BITS-1:0]       r_fk, n_fk;
    logic [sts_pkg::PAYLOAD_BITS-1:0]   r_fp, n_fp;

    logic                               r_o_valid;
    logic                               r_o_success;
    logic [sts_pkg::KEY_BITS-1:0]       r_o_key;
    logic [sts_pkg::PAYLOAD_BITS-1:0]   r_o_pay;
    logic [sts_pkg::CNT_W-1:0]          r_o_count;

    // entry memory: {key, payload}
    logic [sts_pkg::ENT_W-1:0]          r_mem [sts_pkg::SLOTS];
    logic [sts_pkg::ENT_W-1:0]          r_rdata;
    logic                               mem_we;
    sts_pkg::t_idx                      mem_waddr;
    sts_pkg::t_idx                      mem_raddr;
    logic [sts_pkg::ENT_W-1:0]          mem_wdata;

    logic [sts_pkg::KEY_BITS-1:0]       rd_key;
    logic [sts_pkg::PAYLOAD_BITS-1:0]   rd_pay;
    sts_pkg::t_free                     free_slot;
    sts_pkg::t_idx                      jm1;
    logic                               in_acc;
    logic                               out_load;
    logic                               hit;
    logic                               goes_after;

    sts_free_find u_free (
        .i_valid_bits (r_valid),
        .o_free       (free_slot)
    );

    assign rd_key   = r_rdata[sts_pkg::ENT_W-1 -: sts_pkg::KEY_BITS];
    assign rd_pay   = r_rdata[sts_pkg::PAYLOAD_BITS-1:0];
    assign jm1      = r_j - IDX_ONE;
    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == S_FIN) && (!r_o_valid || i_ready);
    assign hit      = r_valid[r_idx] && (rd_key == r_hk);
    // occupied slot j-1 moves past the held word if the held one is empty or has a smaller key
    assign goes_after = r_valid[jm1] && (!r_hv || (rd_key > r_hk));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_count   = r_count;
        n_idx     = r_idx;
        n_i       = r_i;
        n_j       = r_j;
        n_rm      = r_rm;
        n_hv      = r_hv;
        n_hk      = r_hk;
        n_hd      = r_hd;
        n_ok      = r_ok;
        n_fk      = r_fk;
        n_fp      = r_fp;
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = {r_hk, r_hd};
        mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_fk = '0;
                    n_fp = '0;
                    n_hk = i_key_id;
                    case (i_opcode)
                        sts_pkg::OP_INSERT: begin
                            n_ok    = free_slot.found;
                            n_state = S_FIN;
                            if (free_slot.found) begin
                                mem_we                = 1'b1;
                                mem_waddr             = free_slot.idx;
                                mem_wdata             = {i_key_id, i_entry_payload};
                                n_valid[free_slot.idx] = 1'b1;
                                n_count               = r_count + CNT_ONE;
                            end
                        end
                        sts_pkg::OP_REMOVE, sts_pkg::OP_SEARCH: begin
                            n_rm      = (i_opcode == sts_pkg::OP_REMOVE);
                            n_ok      = 1'b0;
                            n_idx     = '0;
                            mem_raddr = '0;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            n_ok      = 1'b1;
                            n_i       = IDX_ONE;
                            mem_raddr = IDX_ONE;
                            n_state   = S_SLOAD;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                mem_raddr = r_idx + IDX_ONE;
                if (hit) begin
                    n_ok    = 1'b1;
                    n_fk    = rd_key;
                    n_fp    = rd_pay;
                    n_state = S_FIN;
                    if (r_rm) begin
                        n_valid[r_idx] = 1'b0;
                        n_count        = r_count - CNT_ONE;
                    end
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + IDX_ONE;
                end
            end
            S_SLOAD: begin
                // hold slot i while occupied neighbors shift up past it: larger keys, or all if i is empty
                n_hv      = r_valid[r_i];
                n_hk      = rd_key;
                n_hd      = rd_pay;
                n_j       = r_i;
                mem_raddr = r_i - IDX_ONE;
                n_state   = S_SCMP;
            end
            S_SCMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                if (goes_after) begin
                    mem_wdata      = r_rdata;
                    n_valid[r_j]   = r_valid[jm1];
                    n_j            = jm1;
                    mem_raddr      = r_j - IDX_TWO;
                    if (r_j == IDX_ONE) begin
                        n_state = S_SPUT;
                    end
                end else begin
                    n_valid[r_j] = r_hv;
                    if (r_i == IDX_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_i       = r_i + IDX_ONE;
                        mem_raddr = r_i + IDX_ONE;
                        n_state   = S_SLOAD;
                    end
                end
            end
            S_SPUT: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                n_valid[0] = r_hv;
                if (r_i == IDX_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_i       = r_i + IDX_ONE;
                    mem_raddr = r_i + IDX_ONE;
                    n_state   = S_SLOAD;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_i   <= n_i;
        r_j   <= n_j;
        r_rm  <= n_rm;
        r_hv  <= n_hv;
        r_hk  <= n_hk;
        r_hd  <= n_hd;
        r_ok  <= n_ok;
        r_fk  <= n_fk;
        r_fp  <= n_fp;
        if (out_load) begin
            r_o_success <= r_ok;
            r_o_key     <= r_fk;
            r_o_pay     <= r_fp;
            r_o_count   <= r_count;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_success        = r_o_success;
    assign o_found_key      = r_o_key;
    assign o_found_payload  = r_o_pay;
    assign o_occupied_count = r_o_count;
    assign o_table_empty    = (r_o_count == '0);
    assign o_table_full     = (r_o_count == CNT_FULL);

`ifndef ASSERT_OFF
    // the valid bits are duplicated while a hole moves down during a sort pass
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_SCMP) && (r_state != S_SPUT))
        |-> (r_count == sts_pkg::CNT_W'($countones(r_valid))))
        else $error("occupied count out of step with valid bits");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_opcode == sts_pkg::OP_INSERT) && free_slot.found)
        |=> (r_count == $past(r_count) + CNT_ONE))
        else $error("insert into free slot did not raise count");

    a_sort_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCMP) || (r_state == S_SPUT) || (r_state == S_SLOAD))
        |=> (r_count == $past(r_count)))
        else $error("sort changed the occupied count");

    a_shift_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP) |-> ((r_j <= r_i) && (r_j != '0)))
        else $error("sort shift index out of range");
`endif

endmodule

FILE: dv/slot_table_with_sort_tb.sv
// Self-checking testbench for the slot table: directed corner cases, then random traffic.
module slot_table_with_sort_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic                             success;
        logic [sts_pkg::KEY_BITS-1:0]     found_key;
        logic [sts_pkg::PAYLOAD_BITS-1:0] found_payload;
        logic [sts_pkg::CNT_W-1:0]        occupied;
        logic                             empty;
        logic                             full;
    } t_reply;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic [1:0]                       i_opcode = sts_pkg::OP_INSERT;
    logic [sts_pkg::KEY_BITS-1:0]     i_key_id = '0;
    logic [sts_pkg::PAYLOAD_BITS-1:0] i_entry_payload = '0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic                             o_success;
    logic [sts_pkg::KEY_BITS-1:0]     o_found_key;
    logic [sts_pkg::PAYLOAD_BITS-1:0] o_found_payload;
    logic [sts_pkg::CNT_W-1:0]        o_occupied_count;
    logic                             o_table_empty;
    logic                             o_table_full;

    // Shadow copy of the slot table
    logic                             tbl_valid [sts_pkg::SLOTS];
    logic [sts_pkg::KEY_BITS-1:0]     tbl_key   [sts_pkg::SLOTS];
    logic [sts_pkg::PAYLOAD_BITS-1:0] tbl_data  [sts_pkg::SLOTS];

    t_reply table_replies[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    slot_table_with_sort u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_key_id         (i_key_id),
        .i_entry_payload  (i_entry_payload),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_success        (o_success),
        .o_found_key      (o_found_key),
        .o_found_payload  (o_found_payload),
        .o_occupied_count (o_occupied_count),
        .o_table_empty    (o_table_empty),
        .o_table_full     (o_table_full)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic t_reply apply_table_op(input logic [1:0] op,
                                              input logic [sts_pkg::KEY_BITS-1:0] key,
                                              input logic [sts_pkg::PAYLOAD_BITS-1:0] pay);
        t_reply                           r;
        int                               hit;
        int                               n;
        int                               j;
        logic                             v;
        logic [sts_pkg::KEY_BITS-1:0]     k;
        logic [sts_pkg::PAYLOAD_BITS-1:0] d;
        r   = '0;
        hit = -1;
        n   = 0;
        case (op)
            sts_pkg::OP_INSERT: begin
                for (int i = 0; i < sts_pkg::SLOTS; i++)
                    if (hit < 0 && !tbl_valid[i])
                        hit = i;
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b1;
                    tbl_key[hit]   = key;
                    tbl_data[hit]  = pay;
                    r.success      = 1'b1;
                end
            end
            sts_pkg::OP_REMOVE, sts_pkg::OP_SEARCH: begin
                for (int i = 0; i < sts_pkg::SLOTS; i++)
                    if (hit < 0 && tbl_valid[i] && tbl_key[i] == key)
                        hit = i;
                if (hit >= 0) begin
                    r.success       = 1'b1;
                    r.found_key     = tbl_key[hit];
                    r.found_payload = tbl_data[hit];
                    if (op == sts_pkg::OP_REMOVE)
                        tbl_valid[hit] = 1'b0;
                end
            end
            default: begin
                // stable insertion sort: empty slots first, then ascending keys
                for (int i = 1; i < sts_pkg::SLOTS; i++) begin
                    v = tbl_valid[i];
                    k = tbl_key[i];
                    d = tbl_data[i];
                    j = i;
                    while (j > 0 && tbl_valid[j-1] && (!v || tbl_key[j-1] > k)) begin
                        tbl_valid[j] = tbl_valid[j-1];
                        tbl_key[j]   = tbl_key[j-1];
                        tbl_data[j]  = tbl_data[j-1];
                        j--;
                    end
                    tbl_valid[j] = v;
                    tbl_key[j]   = k;
                    tbl_data[j]  = d;
                end
                r.success = 1'b1;
            end
        endcase
        for (int i = 0; i < sts_pkg::SLOTS; i++)
            if (tbl_valid[i])
                n++;
        r.occupied = sts_pkg::CNT_W'(n);
        r.empty    = (n == 0);
        r.full     = (n == sts_pkg::SLOTS);
        return r;
    endfunction

    // Half the time a key that is live in the table, so remove and search hit often
    function automatic logic [sts_pkg::KEY_BITS-1:0] pick_key();
        int live[$];
        int roll;
        for (int i = 0; i < sts_pkg::SLOTS; i++)
            if (tbl_valid[i])
                live.push_back(i);
        roll = $urandom_range(0, 99);
        if (roll < 50 && live.size() > 0)
            return tbl_key[live[$urandom_range(0, live.size() - 1)]];
        if (roll < 80)
            return sts_pkg::KEY_BITS'($urandom_range(0, 15));
        return sts_pkg::KEY_BITS'($urandom());
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (table_replies.size() == 0) begin
                $display("%0t unexpected word: expected none actual key %0h payload %0h",
                         $time, o_found_key, o_found_payload);
                mismatch_count++;
            end else begin
                want = table_replies.pop_front();
                check_field("success", want.success, o_success);
                check_field("found_key", want.found_key, o_found_key);
                check_field("found_payload", want.found_payload, o_found_payload);
                check_field("occupied_count", want.occupied, o_occupied_count);
                check_field("table_empty", want.empty, o_table_empty);
                check_field("table_full", want.full, o_table_full);
            end
        end
    end

    // Called at a rising edge; returns at the edge where the word is taken, valid still high
    task automatic push_op(input logic [1:0] op, input logic [sts_pkg::KEY_BITS-1:0] key,
                           input logic [sts_pkg::PAYLOAD_BITS-1:0] pay);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_key_id        <= key;
        i_entry_payload <= pay;
        do @(posedge i_clk); while (!o_ready);
        table_replies.push_back(apply_table_op(op, key, pay));
    endtask

    task automatic test_empty_table();
        push_op(sts_pkg::OP_SEARCH, 16'h0000, 32'hFFFF_FFFF);
        push_op(sts_pkg::OP_REMOVE, 16'hFFFF, 32'h0000_0000);
        push_op(sts_pkg::OP_SORT, 16'hA5A5, 32'h5A5A_5A5A);
    endtask

    task automatic test_key_extremes_and_duplicates();
        push_op(sts_pkg::OP_INSERT, 16'h0000, 32'hFFFF_FFFF);
        push_op(sts_pkg::OP_INSERT, 16'hFFFF, 32'h0000_0000);
        push_op(sts_pkg::OP_INSERT, 16'hFFFF, 32'h1234_5678);
        push_op(sts_pkg::OP_SEARCH, 16'hFFFF, 32'h0);
        push_op(sts_pkg::OP_REMOVE, 16'hFFFF, 32'h0);
        push_op(sts_pkg::OP_SEARCH, 16'hFFFF, 32'h0);
        push_op(sts_pkg::OP_REMOVE, 16'h0000, 32'h0);
        // stale key left in a freed slot must not match
        push_op(sts_pkg::OP_SEARCH, 16'h0000, 32'h0);
        push_op(sts_pkg::OP_REMOVE, 16'h0005, 32'h0);
    endtask

    task automatic test_fill_and_sort();
        for (int i = 0; i < sts_pkg::SLOTS - 1; i++)
            push_op(sts_pkg::OP_INSERT, sts_pkg::KEY_BITS'(16'h00F0 - (i / 2) * 8),
                    $urandom());
        push_op(sts_pkg::OP_INSERT, 16'h0001, 32'hDEAD_BEEF);
        push_op(sts_pkg::OP_SORT, 16'h0, 32'h0);
        push_op(sts_pkg::OP_SORT, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_mix(input int n_items, input int send_idle,
                                   input int recv_stall);
        int         roll;
        bit         filling;
        logic [1:0] op;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        filling        = 1'b0;
        for (int n = 0; n < n_items; n++) begin
            // swing occupancy between empty and full
            if ($urandom_range(0, 39) == 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            if (filling)
                op = (roll < 55) ? sts_pkg::OP_INSERT : (roll < 72) ? sts_pkg::OP_REMOVE :
                     (roll < 90) ? sts_pkg::OP_SEARCH : sts_pkg::OP_SORT;
            else
                op = (roll < 15) ? sts_pkg::OP_INSERT : (roll < 65) ? sts_pkg::OP_REMOVE :
                     (roll < 90) ? sts_pkg::OP_SEARCH : sts_pkg::OP_SORT;
            push_op(op, pick_key(), $urandom());
        end
    endtask

    initial begin
        for (int i = 0; i < sts_pkg::SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_data[i]  = '0;
        end
        send_idle_pct  = 8;
        recv_stall_pct = 72;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_key_extremes_and_duplicates();
        test_fill_and_sort();
        test_random_mix(630, 8, 72);
        test_random_mix(630, 72, 8);
        test_random_mix(630, 0, 0);

        i_valid <= 1'b0;
        while (table_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && table_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
